// ===== src/dsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Deskew package
// Types and constants shared by the lidar deskew modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dsk_pkg;

  // Item codes as they arrive in the kind field.
  typedef enum logic [1:0] {
    OP_POSE  = 2'd0,
    OP_EXT   = 2'd1,
    OP_END   = 2'd2,
    OP_POINT = 2'd3
  } dsk_op_t;

  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [1:0]  ROW_LAST = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  pose_slot;
    logic [1:0]  row_number;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] coef_c;
    logic [31:0] offset_term;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [19:0] time_offset_us;
    logic [7:0]  intensity;
  } dsk_in_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [7:0]  out_intensity;
  } dsk_out_t;

  // Internal word. For loads, word holds the three coefficients and the
  // offset; for points, word[0..2] hold the coordinates.
  typedef struct packed {
    dsk_op_t          op;
    logic [6:0]       slot;
    logic [1:0]       row;
    logic [3:0][31:0] word;
    logic [19:0]      time_us;
    logic [7:0]       intensity;
  } dsk_item_t;

  typedef logic [2:0][2:0][31:0] dsk_rot_t;
  typedef logic [2:0][31:0]      dsk_vec_t;

  localparam dsk_rot_t ROT_IDENTITY = {ONE_Q30, 32'd0, 32'd0,
                                       32'd0, ONE_Q30, 32'd0,
                                       32'd0, 32'd0, ONE_Q30};

endpackage

`default_nettype wire

// ===== src/dsk_front.sv =====
// ----------------------------------------------------------------------------
// Deskew front end
// Accepts input words, decodes the kind and drops loads that write nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module dsk_front
  import dsk_pkg::*;
#(
  parameter int POSE_DEPTH = 128
) (
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dsk_in_t   in_data,
  input  wire logic      q_full,
  output logic           push,
  output dsk_item_t      item
);

  dsk_op_t op_c;
  logic    keep_c;

  always_comb begin
    op_c   = dsk_op_t'(in_data.kind);
    keep_c = 1'b1;
    if (op_c != OP_POINT) begin
      if (in_data.row_number > ROW_LAST) begin
        keep_c = 1'b0;
      end
      if (op_c == OP_POSE && {25'd0, in_data.pose_slot} >= 32'(POSE_DEPTH)) begin
        keep_c = 1'b0;
      end
    end
  end

  always_comb begin
    item.op        = op_c;
    item.slot      = in_data.pose_slot;
    item.row       = in_data.row_number;
    item.time_us   = in_data.time_offset_us;
    item.intensity = in_data.intensity;
    if (op_c == OP_POINT) begin
      item.word = {32'd0, in_data.point_z, in_data.point_y, in_data.point_x};
    end else begin
      item.word = {in_data.offset_term, in_data.coef_c, in_data.coef_b, in_data.coef_a};
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep_c;

endmodule

`default_nettype wire

// ===== src/dsk_queue.sv =====
// ----------------------------------------------------------------------------
// Deskew queue
// Four-entry queue between the front end and the transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module dsk_queue
  import dsk_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire dsk_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output dsk_item_t      head_item
);

  dsk_item_t  store_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = (count_r == 3'd4);
  assign head_valid = (count_r != 3'd0);
  assign head_item  = store_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {2'd0, push} - {2'd0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/dsk_xform.sv =====
// ----------------------------------------------------------------------------
// Deskew rigid transform
// Registered rotate, round, translate and saturate of points for one frame change; loads pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module dsk_xform
  import dsk_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire dsk_item_t in_item,
  input  wire dsk_rot_t  rot,
  input  wire dsk_vec_t  trans,
  output logic           out_valid,
  output dsk_item_t      out_item
);

  logic [2:0][2:0][63:0] prod_r, prod_nxt;
  logic [2:0][35:0]      rnd_r, rnd_nxt;
  dsk_vec_t              tra_r, trb_r;
  dsk_item_t             ia_r, ib_r, ic_r, ic_nxt;
  logic                  va_r, vb_r, vc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed({{32{rot[i][j][31]}}, rot[i][j]})
                       * $signed({{32{in_item.word[j][31]}}, in_item.word[j]});
      end
    end
  end

  // Half-up rounding from Q18.46 down to Q20.16.
  always_comb begin
    logic [65:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = {{2{prod_r[i][0][63]}}, prod_r[i][0]}
          + {{2{prod_r[i][1][63]}}, prod_r[i][1]}
          + {{2{prod_r[i][2][63]}}, prod_r[i][2]}
          + 66'h0_0000_0000_2000_0000;
      rnd_nxt[i] = sum[65:30];
    end
  end

  always_comb begin
    logic [36:0] v;
    ic_nxt = ib_r;
    for (int i = 0; i < 3; i++) begin
      v = {rnd_r[i][35], rnd_r[i]} + {{5{trb_r[i][31]}}, trb_r[i]};
      if (ib_r.op == OP_POINT) begin
        if (!v[36] && v[35:31] != 5'd0) begin
          ic_nxt.word[i] = 32'h7FFF_FFFF;
        end else if (v[36] && v[35:31] != 5'h1F) begin
          ic_nxt.word[i] = 32'h8000_0000;
        end else begin
          ic_nxt.word[i] = v[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      tra_r  <= trans;
      ia_r   <= in_item;
      rnd_r  <= rnd_nxt;
      trb_r  <= tra_r;
      ib_r   <= ia_r;
      ic_r   <= ic_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_item  = ic_r;

endmodule

`default_nettype wire

// ===== src/dsk_back.sv =====
// ----------------------------------------------------------------------------
// Deskew back end
// Frame tables, pose memory, pose index and the three chained transforms.
// ----------------------------------------------------------------------------
`default_nettype none

module dsk_back
  import dsk_pkg::*;
#(
  parameter int POSE_DEPTH       = 128,
  parameter int POSE_INTERVAL_US = 1000
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic      head_valid,
  input  wire dsk_item_t head_item,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dsk_out_t       out_data
);

  localparam int          IDX_W = (POSE_DEPTH > 1) ? $clog2(POSE_DEPTH) : 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / POSE_INTERVAL_US);
  localparam logic [37:0] DIV_D = 38'(POSE_INTERVAL_US);

  logic       en;
  logic [7:0] pose_count_r;

  dsk_rot_t   ext_rot_r, end_rot_r, pose_rot;
  dsk_vec_t   ext_tr_r, end_tr_r, pose_tr;

  logic       e_valid, x_valid, z_valid;
  dsk_item_t  e_item, x_item, z_item;
  logic       p_valid_r;
  dsk_item_t  p_item_r;

  logic [19:0] t_in;
  logic [20:0] qa_r;
  logic [19:0] ta_r;
  logic [20:0] qb_r, qb_nxt;
  logic [37:0] rem_c;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [12:0] lim_c;
  logic [IDX_W-1:0] lim_m1_c;

  logic [3:0][31:0] pose_mem0 [POSE_DEPTH];
  logic [3:0][31:0] pose_mem1 [POSE_DEPTH];
  logic [3:0][31:0] pose_mem2 [POSE_DEPTH];
  logic [3:0][31:0] rd0_r, rd1_r, rd2_r;
  logic [IDX_W-1:0] wr_addr;
  logic             pose_we;

  logic       out_valid_r;
  dsk_out_t   out_data_r;

  // The whole pipeline moves together; it halts only while a finished
  // word waits at the output and is stalled.
  assign en  = !out_valid_r || !out_stall;
  assign pop = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_count_r <= 8'd1;
    end else if (cfg_wr_en) begin
      pose_count_r <= cfg_wr_data;
    end
  end

  // Extrinsic table is read and written where words enter the pipeline, so
  // each word sees exactly the loads that came before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_rot_r <= ROT_IDENTITY;
      ext_tr_r  <= '0;
    end else if (en && head_valid && head_item.op == OP_EXT) begin
      ext_rot_r[head_item.row] <= head_item.word[2:0];
      ext_tr_r[head_item.row]  <= head_item.word[3];
    end
  end

  dsk_xform u_ext (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (head_valid),
    .in_item   (head_item),
    .rot       (ext_rot_r),
    .trans     (ext_tr_r),
    .out_valid (e_valid),
    .out_item  (e_item)
  );

  // Pose index: reciprocal estimate, one correction step, then the clamp.
  // An empty queue feeds a zero time so the index path always holds known values.
  assign t_in = head_valid ? head_item.time_us : 20'd0;

  always_comb begin
    rem_c  = {18'd0, ta_r} - {17'd0, qa_r} * DIV_D;
    qb_nxt = (rem_c >= DIV_D) ? qa_r + 21'd1 : qa_r;
  end

  always_comb begin
    if (pose_count_r == 8'd0) begin
      lim_c = 13'd1;
    end else if ({5'd0, pose_count_r} > 13'(POSE_DEPTH)) begin
      lim_c = 13'(POSE_DEPTH);
    end else begin
      lim_c = {5'd0, pose_count_r};
    end
    lim_m1_c = IDX_W'(lim_c - 13'd1);
    if (qb_r > {8'd0, lim_c - 13'd1}) begin
      idx_nxt = lim_m1_c;
    end else begin
      idx_nxt = IDX_W'(qb_r);
    end
  end

  always_ff @(posedge clk) begin
    logic [52:0] p;
    if (en) begin
      p     = {33'd0, t_in} * {20'd0, RECIP};
      qa_r  <= p[52:32];
      ta_r  <= t_in;
      qb_r  <= qb_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Pose memory: one array per matrix row, written by pose loads and read
  // at the selected entry in the same pipeline position.
  assign wr_addr = IDX_W'(e_item.slot);
  assign pose_we = en && e_valid && e_item.op == OP_POSE;

  always_ff @(posedge clk) begin
    if (pose_we && e_item.row == 2'd0) begin
      pose_mem0[wr_addr] <= e_item.word;
    end
    if (en) begin
      rd0_r <= pose_mem0[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pose_we && e_item.row == 2'd1) begin
      pose_mem1[wr_addr] <= e_item.word;
    end
    if (en) begin
      rd1_r <= pose_mem1[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pose_we && e_item.row == ROW_LAST) begin
      pose_mem2[wr_addr] <= e_item.word;
    end
    if (en) begin
      rd2_r <= pose_mem2[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_item_r <= e_item;
    end
  end

  assign pose_rot = {rd2_r[2:0], rd1_r[2:0], rd0_r[2:0]};
  assign pose_tr  = {rd2_r[3], rd1_r[3], rd0_r[3]};

  dsk_xform u_pose (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid_r),
    .in_item   (p_item_r),
    .rot       (pose_rot),
    .trans     (pose_tr),
    .out_valid (x_valid),
    .out_item  (x_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_rot_r <= ROT_IDENTITY;
      end_tr_r  <= '0;
    end else if (en && x_valid && x_item.op == OP_END) begin
      end_rot_r[x_item.row] <= x_item.word[2:0];
      end_tr_r[x_item.row]  <= x_item.word[3];
    end
  end

  dsk_xform u_end (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x_valid),
    .in_item   (x_item),
    .rot       (end_rot_r),
    .trans     (end_tr_r),
    .out_valid (z_valid),
    .out_item  (z_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= z_valid && z_item.op == OP_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.out_x         <= z_item.word[0];
      out_data_r.out_y         <= z_item.word[1];
      out_data_r.out_z         <= z_item.word[2];
      out_data_r.out_intensity <= z_item.intensity;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The reciprocal estimate is never more than one below the quotient.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_c < (DIV_D << 1))
    else $error("pose index correction out of range");

  a_idx_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(POSE_DEPTH - 1))
    else $error("pose index beyond table depth");

  a_point_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && z_valid && z_item.op == OP_POINT |=> out_valid_r)
    else $error("finished point not presented");

  a_load_drop: assert property (@(posedge clk) disable iff (!rst_n)
    en && !(z_valid && z_item.op == OP_POINT) |=> !out_valid_r)
    else $error("output raised without a point");

endmodule

`default_nettype wire

// ===== src/lidar_point_deskew_transform.sv =====
// ----------------------------------------------------------------------------
// Lidar point deskew transform
// Maps lidar points through extrinsic, per-time pose and end-frame transforms.
// ----------------------------------------------------------------------------
// One word is taken per clock cycle when the output is not stalled; a
// four-word queue sits behind the input. From the queue a point passes the
// extrinsic transform, the registered pose memory read, the pose and
// end-frame transforms and one output register; each transform registers
// multiply, round, and translate and saturate. Load words travel the same
// pipeline and update their table at the position where points read it, so
// every point sees exactly the loads sent before it. Pose entries have no
// reset value and there is no clearing pass; the extrinsic and end-frame
// tables reset to identity. Write pose_count only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_deskew_transform
  import dsk_pkg::*;
#(
  parameter int POSE_DEPTH       = 128,
  parameter int POSE_INTERVAL_US = 1000
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dsk_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dsk_out_t        out_data
);

  logic      q_full, push, head_valid, pop;
  dsk_item_t push_item, head_item;

  dsk_front #(.POSE_DEPTH(POSE_DEPTH)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  dsk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dsk_back #(
    .POSE_DEPTH       (POSE_DEPTH),
    .POSE_INTERVAL_US (POSE_INTERVAL_US)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
